[src/tpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared constants, types and helper functions for the triangle plane clipper.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int NUM_CFG   = 6;
  localparam int CFG_IDX_W = 3;
  // side value: sum of six floored Q products
  localparam int SIDE_W    = 67 - FRAC_BITS;
  localparam int DIFF_W    = SIDE_W + 1;
  localparam int REM_W     = DIFF_W + 1;
  localparam int DLT_W     = WORD_W + 1;
  localparam int IP_W      = FRAC_BITS + 1 + DLT_W;
  localparam int CNT_W     = $clog2(FRAC_BITS + 2);

  // register indexes
  localparam int REG_NRM_X = 0;
  localparam int REG_NRM_Y = 1;
  localparam int REG_NRM_Z = 2;
  localparam int REG_PT_X  = 3;
  localparam int REG_PT_Y  = 4;
  localparam int REG_PT_Z  = 5;

  localparam logic [WORD_W-1:0] ONE_Q = WORD_W'(1) << FRAC_BITS;

  // component k: 0..2 position x/y/z, 3..5 normal x/y/z
  typedef logic [5:0][WORD_W-1:0] vertex_t;

  typedef enum logic [1:0] {KIND_DROP, KIND_PASS, KIND_TWO, KIND_ONE} clip_kind_t;
  typedef enum logic [2:0] {SRC_V0, SRC_V1, SRC_V2, SRC_A, SRC_B} src_t;

  typedef struct packed {
    clip_kind_t  kind;
    logic [1:0]  lone;
  } class_t;

  typedef struct packed {
    logic        in_load;
    logic [1:0]  wr_row;
    logic        acc_clr;
    logic        side_mul;
    logic [2:0]  side_k;
    logic        side_store;
    logic [1:0]  side_row;
    logic        div_load;
    logic        div_step;
    logic [1:0]  row_i;
    logic [1:0]  row_j;
    logic        interp_mul;
    logic [2:0]  interp_k;
    logic        interp_to_b;
    logic        out_load;
    src_t        out_src;
    logic        out_ends;
    logic        out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] pos;
    logic [2:0] neg;
  } dp_stat_t;

  function automatic class_t classify(input logic [2:0] pos, input logic [2:0] neg);
    class_t c;
    logic [2:0] lone_mask;
    c.kind = KIND_DROP;
    c.lone = 2'd0;
    lone_mask = 3'b000;
    if (neg == 3'b000) begin
      c.kind = KIND_DROP;
    end else if (pos == 3'b000) begin
      c.kind = KIND_PASS;
    end else if ((pos | neg) != 3'b111) begin
      c.kind = KIND_DROP;
    end else if ($onehot(pos)) begin
      c.kind = KIND_TWO;
      lone_mask = pos;
    end else begin
      c.kind = KIND_ONE;
      lone_mask = neg;
    end
    c.lone = lone_mask[0] ? 2'd0 : (lone_mask[1] ? 2'd1 : 2'd2);
    return c;
  endfunction

  // far vertex of cut a or cut b for a given lone vertex
  function automatic logic [1:0] cut_far(input logic [1:0] lone, input logic second);
    if (second) begin
      return (lone == 2'd2) ? 2'd0 : 2'd2;
    end
    return (lone == 2'd1) ? 2'd0 : 2'd1;
  endfunction

  function automatic src_t emit_src(input clip_kind_t kind, input logic [1:0] lone,
                                    input logic [2:0] idx);
    src_t seq [6];
    seq = '{SRC_V0, SRC_V1, SRC_V2, SRC_V0, SRC_V1, SRC_V2};
    case (kind)
      KIND_TWO: begin
        case (lone)
          2'd0: seq = '{SRC_A, SRC_V1, SRC_V2, SRC_A, SRC_V2, SRC_B};
          2'd1: seq = '{SRC_V0, SRC_A, SRC_B, SRC_V0, SRC_B, SRC_V2};
          default: seq = '{SRC_V0, SRC_V1, SRC_A, SRC_V0, SRC_A, SRC_B};
        endcase
      end
      KIND_ONE: begin
        case (lone)
          2'd0: seq = '{SRC_V0, SRC_A, SRC_B, SRC_V0, SRC_A, SRC_B};
          2'd1: seq = '{SRC_A, SRC_V1, SRC_B, SRC_A, SRC_V1, SRC_B};
          default: seq = '{SRC_B, SRC_A, SRC_V2, SRC_B, SRC_A, SRC_V2};
        endcase
      end
      default: seq = '{SRC_V0, SRC_V1, SRC_V2, SRC_V0, SRC_V1, SRC_V2};
    endcase
    if (idx > 3'd5) begin
      return SRC_V0;
    end
    return seq[idx];
  endfunction

endpackage
`default_nettype wire

[src/tpc_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpc interfaces
// Valid/ready channels for input vertices and emitted vertices.
// ----------------------------------------------------------------------------
interface tpc_vtx_if;
  import tpc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] pos_x;
  logic signed [WORD_W-1:0] pos_y;
  logic signed [WORD_W-1:0] pos_z;
  logic signed [WORD_W-1:0] nrm_x;
  logic signed [WORD_W-1:0] nrm_y;
  logic signed [WORD_W-1:0] nrm_z;
  modport source(output valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, output ready);
endinterface

interface tpc_res_if;
  import tpc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] out_pos_x;
  logic signed [WORD_W-1:0] out_pos_y;
  logic signed [WORD_W-1:0] out_pos_z;
  logic signed [WORD_W-1:0] out_nrm_x;
  logic signed [WORD_W-1:0] out_nrm_y;
  logic signed [WORD_W-1:0] out_nrm_z;
  logic                     ends_triangle;
  logic                     last_of_run;
  modport source(output valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
                 out_nrm_z, ends_triangle, last_of_run, input ready);
  modport sink(input valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
               out_nrm_z, ends_triangle, last_of_run, output ready);
endinterface
`default_nettype wire

[src/triangle_plane_clipper.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_plane_clipper
// Clips a stream of triangles, one vertex per item, against one plane.
//
// in_vtx carries one vertex (position and normal, signed Q15.16) per item;
// out_res carries emitted vertices, ends_triangle marks each third vertex
// and last_of_run the final vertex caused by one input item. The plane is
// set through cfg_we/cfg_idx/cfg_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce. Each vertex
// runs a side pass before the next is accepted: one shared 32x32
// multiplier forms the six products of the side value. The third
// vertex adds a classify step, then per cut vertex the one-bit-a-cycle
// divider and the interpolator, then a read and a load state per emitted
// vertex; no new item is taken until the last emitted vertex is loaded.
// Results sit in an output register; the next item is taken while the
// last result still waits, and a stalled receiver holds emission.
// Reset clears the vertex count, the plane to z = 0 with normal +z, and
// any pending result.
// ----------------------------------------------------------------------------
module triangle_plane_clipper (
  input  wire                            clk,
  input  wire                            rst_n,
  tpc_vtx_if.sink                        in_vtx,
  tpc_res_if.source                      out_res,
  input  wire                            cfg_we,
  input  wire  [tpc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire  [tpc_pkg::WORD_W-1:0]     cfg_wdata
);
  import tpc_pkg::*;

  vertex_t  in_vert;
  vertex_t  out_vert;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     out_ends;
  logic     out_last;

  assign in_vert[0] = in_vtx.pos_x;
  assign in_vert[1] = in_vtx.pos_y;
  assign in_vert[2] = in_vtx.pos_z;
  assign in_vert[3] = in_vtx.nrm_x;
  assign in_vert[4] = in_vtx.nrm_y;
  assign in_vert[5] = in_vtx.nrm_z;

  tpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_vtx.valid),
    .in_ready  (in_vtx.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tpc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_vert   (in_vert),
    .cmd       (cmd),
    .stat      (stat),
    .out_vert  (out_vert),
    .out_ends  (out_ends),
    .out_last  (out_last)
  );

  assign out_res.out_pos_x     = out_vert[0];
  assign out_res.out_pos_y     = out_vert[1];
  assign out_res.out_pos_z     = out_vert[2];
  assign out_res.out_nrm_x     = out_vert[3];
  assign out_res.out_nrm_y     = out_vert[4];
  assign out_res.out_nrm_z     = out_vert[5];
  assign out_res.ends_triangle = out_ends;
  assign out_res.last_of_run   = out_last;

endmodule
`default_nettype wire

[src/tpc_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_dp
// Datapath: plane registers, vertex memory, side accumulator, fraction
// divider, interpolator and output register.
// ----------------------------------------------------------------------------
module tpc_dp (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire  [tpc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire  [tpc_pkg::WORD_W-1:0]       cfg_wdata,
  input  tpc_pkg::vertex_t                 in_vert,
  input  tpc_pkg::dp_cmd_t                 cmd,
  output tpc_pkg::dp_stat_t                stat,
  output tpc_pkg::vertex_t                 out_vert,
  output logic                             out_ends,
  output logic                             out_last
);
  import tpc_pkg::*;

  logic [NUM_CFG-1:0][WORD_W-1:0] cfg_r;
  vertex_t                        in_r;
  vertex_t                        mem_r [3];
  vertex_t                        rd_a_r;
  vertex_t                        rd_b_r;

  logic signed [WORD_W-1:0]       mul_n;
  logic signed [WORD_W-1:0]       mul_v;
  logic signed [2*WORD_W-1:0]     prod_r;
  logic signed [2*WORD_W-1:0]     prod_sh;
  logic                           acc_en_r;
  logic                           sub_r;
  logic signed [SIDE_W-1:0]       acc_r;
  logic signed [SIDE_W-1:0]       term;
  logic signed [SIDE_W-1:0]       sd_r [3];
  logic signed [SIDE_W-1:0]       si_r;

  logic signed [DIFF_W-1:0]       si_x;
  logic signed [DIFF_W-1:0]       sj_x;
  logic signed [DIFF_W-1:0]       diff;
  logic        [DIFF_W-1:0]       abs_diff;
  logic        [DIFF_W-1:0]       abs_si;
  logic        [REM_W-1:0]        rem_r;
  logic        [REM_W-1:0]        den_r;
  logic        [REM_W-1:0]        rem2;
  logic        [FRAC_BITS-1:0]    q_r;

  logic signed [WORD_W-1:0]       vi;
  logic signed [WORD_W-1:0]       vj;
  logic signed [DLT_W-1:0]        dlt;
  logic signed [FRAC_BITS:0]      tq;
  logic signed [IP_W-1:0]         ip_r;
  logic signed [IP_W-1:0]         ip_sh;
  logic signed [WORD_W-1:0]       vi_d_r;
  logic        [2:0]              k_d_r;
  logic                           wr_d_r;
  logic                           to_b_d_r;
  vertex_t                        cut_a_r;
  vertex_t                        cut_b_r;
  logic        [WORD_W-1:0]       cut_val;

  vertex_t                        out_r;
  logic                           ends_r;
  logic                           last_r;

  // plane registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= {{((NUM_CFG - REG_NRM_Z - 1) * WORD_W){1'b0}}, ONE_Q,
                {(REG_NRM_Z * WORD_W){1'b0}}};
    end else if (cfg_we && (cfg_idx < CFG_IDX_W'(NUM_CFG))) begin
      cfg_r[cfg_idx] <= cfg_wdata;
    end
  end

  // vertex memory, one row per vertex
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      mem_r[cmd.wr_row] <= in_vert;
      in_r              <= in_vert;
    end
    rd_a_r <= mem_r[cmd.row_i];
    rd_b_r <= mem_r[cmd.row_j];
  end

  // side = n.pos - n.point, one product a cycle
  always_comb begin
    case (cmd.side_k)
      3'd0: begin mul_n = cfg_r[REG_NRM_X]; mul_v = in_r[0]; end
      3'd1: begin mul_n = cfg_r[REG_NRM_Y]; mul_v = in_r[1]; end
      3'd2: begin mul_n = cfg_r[REG_NRM_Z]; mul_v = in_r[2]; end
      3'd3: begin mul_n = cfg_r[REG_NRM_X]; mul_v = cfg_r[REG_PT_X]; end
      3'd4: begin mul_n = cfg_r[REG_NRM_Y]; mul_v = cfg_r[REG_PT_Y]; end
      3'd5: begin mul_n = cfg_r[REG_NRM_Z]; mul_v = cfg_r[REG_PT_Z]; end
      default: begin mul_n = '0; mul_v = '0; end
    endcase
  end

  assign prod_sh = prod_r >>> FRAC_BITS;
  assign term    = prod_sh[SIDE_W-1:0];

  always_ff @(posedge clk) begin
    prod_r <= mul_n * mul_v;
    if (!rst_n) begin
      acc_en_r <= 1'b0;
      sub_r    <= 1'b0;
    end else begin
      acc_en_r <= cmd.side_mul;
      sub_r    <= (cmd.side_k > 3'd2);
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (acc_en_r) begin
      acc_r <= sub_r ? (acc_r - term) : (acc_r + term);
    end
    if (cmd.side_store) begin
      sd_r[cmd.side_row] <= acc_r;
    end
  end

  always_comb begin
    for (int m = 0; m < 3; m++) begin
      stat.neg[m] = sd_r[m][SIDE_W-1];
      stat.pos[m] = !sd_r[m][SIDE_W-1] && (sd_r[m] != '0);
    end
  end

  // restoring divider: t = |si| / |sj - si|, one bit a cycle
  assign si_x     = DIFF_W'(si_r);
  assign sj_x     = DIFF_W'(sd_r[cmd.row_j]);
  assign diff     = sj_x - si_x;
  assign abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign abs_si   = si_x[DIFF_W-1] ? DIFF_W'(-si_x) : DIFF_W'(si_x);
  assign rem2     = {rem_r[REM_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    si_r <= sd_r[cmd.row_i];
    if (cmd.div_load) begin
      rem_r <= REM_W'(abs_si);
      den_r <= REM_W'(abs_diff);
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (rem2 >= den_r) begin
        rem_r <= rem2 - den_r;
        q_r   <= {q_r[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_r <= rem2;
        q_r   <= {q_r[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  // interpolation: vi + floor(t * (vj - vi) / 2^F), one component a cycle
  assign vi      = rd_a_r[cmd.interp_k];
  assign vj      = rd_b_r[cmd.interp_k];
  assign dlt     = DLT_W'(vj) - DLT_W'(vi);
  assign tq      = {1'b0, q_r};
  assign ip_sh   = ip_r >>> FRAC_BITS;
  assign cut_val = vi_d_r + ip_sh[WORD_W-1:0];

  always_ff @(posedge clk) begin
    ip_r     <= tq * dlt;
    vi_d_r   <= vi;
    k_d_r    <= cmd.interp_k;
    to_b_d_r <= cmd.interp_to_b;
    if (!rst_n) begin
      wr_d_r <= 1'b0;
    end else begin
      wr_d_r <= cmd.interp_mul;
    end
    if (wr_d_r) begin
      if (to_b_d_r) begin
        cut_b_r[k_d_r] <= cut_val;
      end else begin
        cut_a_r[k_d_r] <= cut_val;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_src)
        SRC_A:   out_r <= cut_a_r;
        SRC_B:   out_r <= cut_b_r;
        default: out_r <= rd_a_r;
      endcase
      ends_r <= cmd.out_ends;
      last_r <= cmd.out_last;
    end
  end

  assign out_vert = out_r;
  assign out_ends = ends_r;
  assign out_last = last_r;

endmodule
`default_nettype wire

[src/tpc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_ctrl
// Controller: vertex counting, side pass, cut sequencing and emission.
// ----------------------------------------------------------------------------
module tpc_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  input  tpc_pkg::dp_stat_t    stat,
  output tpc_pkg::dp_cmd_t     cmd
);
  import tpc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SIDE, ST_CLASS, ST_DIV, ST_INTERP, ST_EMIT_RD, ST_EMIT_LD
  } state_t;

  state_t           state_r;
  logic [1:0]       phase_r;
  logic [CNT_W-1:0] cnt_r;
  clip_kind_t       kind_r;
  logic [1:0]       lone_r;
  logic             cut_b_r;
  logic [2:0]       e_r;
  logic             out_valid_r;

  logic             in_fire;
  logic             out_free;
  logic [2:0]       e_last;
  src_t             src;
  class_t           cls;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign e_last    = (kind_r == KIND_TWO) ? 3'd5 : 3'd2;
  assign src       = emit_src(kind_r, lone_r, e_r);
  assign cls       = classify(stat.pos, stat.neg);

  always_comb begin
    cmd             = '0;
    cmd.out_src     = src;
    cmd.wr_row      = phase_r;
    cmd.in_load     = in_fire;
    cmd.acc_clr     = in_fire;
    cmd.side_k      = 3'(cnt_r);
    cmd.side_row    = phase_r;
    cmd.row_i       = lone_r;
    cmd.row_j       = cut_far(lone_r, cut_b_r);
    cmd.interp_k    = 3'(cnt_r - CNT_W'(1));
    cmd.interp_to_b = cut_b_r;
    cmd.out_ends    = (e_r == 3'd2) || (e_r == 3'd5);
    cmd.out_last    = (e_r == e_last);
    case (state_r)
      ST_SIDE: begin
        cmd.side_mul   = (cnt_r < CNT_W'(6));
        cmd.side_store = (cnt_r == CNT_W'(7));
      end
      ST_DIV: begin
        cmd.div_load = (cnt_r == CNT_W'(1));
        cmd.div_step = (cnt_r > CNT_W'(1));
      end
      ST_INTERP: begin
        cmd.interp_mul = (cnt_r != '0) && (cnt_r < CNT_W'(7));
      end
      ST_EMIT_RD, ST_EMIT_LD: begin
        cmd.row_i    = 2'(src);
        cmd.out_load = (state_r == ST_EMIT_LD) && out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 2'd0;
      cnt_r       <= '0;
      kind_r      <= KIND_DROP;
      lone_r      <= 2'd0;
      cut_b_r     <= 1'b0;
      e_r         <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      // the load state sets valid itself whenever the register frees
      if (out_valid_r && out_ready && (state_r != ST_EMIT_LD)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            // a third vertex seen with phase stuck at 3 acts as the third
            if (phase_r == 2'd3) begin
              phase_r <= 2'd2;
            end
            cnt_r   <= '0;
            state_r <= ST_SIDE;
          end
        end
        ST_SIDE: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(7)) begin
            if (phase_r < 2'd2) begin
              phase_r <= phase_r + 2'd1;
              state_r <= ST_IDLE;
            end else begin
              phase_r <= 2'd0;
              state_r <= ST_CLASS;
            end
          end
        end
        ST_CLASS: begin
          kind_r  <= cls.kind;
          lone_r  <= cls.lone;
          cut_b_r <= 1'b0;
          cnt_r   <= '0;
          e_r     <= 3'd0;
          case (cls.kind)
            KIND_DROP: state_r <= ST_IDLE;
            KIND_PASS: state_r <= ST_EMIT_RD;
            default:   state_r <= ST_DIV;
          endcase
        end
        ST_DIV: begin
          if (cnt_r == CNT_W'(FRAC_BITS + 1)) begin
            cnt_r   <= '0;
            state_r <= ST_INTERP;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        ST_INTERP: begin
          if (cnt_r == CNT_W'(7)) begin
            cnt_r <= '0;
            if (!cut_b_r) begin
              cut_b_r <= 1'b1;
              state_r <= ST_DIV;
            end else begin
              state_r <= ST_EMIT_RD;
            end
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        ST_EMIT_RD: begin
          state_r <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            e_r         <= e_r + 3'd1;
            state_r     <= (e_r == e_last) ? ST_IDLE : ST_EMIT_RD;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/tpc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_checker
// Port-level checks for the triangle plane clipper.
// ----------------------------------------------------------------------------
module tpc_checker (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready
);

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // reset drops any pending result
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // side pass keeps the block busy after an item
  a_busy_1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken during side pass");

  a_busy_2: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 !in_ready)
    else $error("item taken during side pass");

endmodule

bind triangle_plane_clipper tpc_checker u_tpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_vtx.valid),
  .in_ready  (in_vtx.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready)
);
`default_nettype wire
